>>> src/egs_pkg.sv
// ---------------------------------------------------------------------------
// Exposure gain splitter package
// Shared types and constants for the gain splitter controller and datapath.
// ---------------------------------------------------------------------------
package egs_pkg;

  localparam int unsigned NumBits = 64;
  localparam int unsigned QuotBits = 25;
  localparam int unsigned TableSteps = 8;
  localparam logic [23:0] DgainMax = 24'hFFFFFF;

  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegCount = 3'd1;
  localparam logic [2:0] RegMaxGain = 3'd2;
  localparam logic [2:0] RegBright = 3'd3;
  localparam logic [2:0] RegBlack = 3'd4;
  localparam logic [2:0] RegShift = 3'd5;
  localparam logic [2:0] RegLow = 3'd6;
  localparam logic [2:0] RegHigh = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MULT,
    ST_DIVIDE,
    ST_FINISH,
    ST_OUTPUT
  } egs_state_t;

  typedef struct packed {
    logic load;
    logic search_step;
    logic mult_step;
    logic div_start;
    logic div_step;
    logic finish;
  } egs_cmd_t;

  typedef struct packed {
    logic search_done;
    logic mult_done;
    logic div_done;
  } egs_status_t;

endpackage

>>> src/egs_datapath.sv
// ---------------------------------------------------------------------------
// Gain splitter datapath
// Table search, coefficient products and a restoring divider, one step a cycle while commanded.
// ---------------------------------------------------------------------------
module egs_datapath
  import egs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  egs_cmd_t          cmd,
  output egs_status_t       status,
  input  logic [15:0]       total_in,
  input  logic [3:0]        table_count,
  input  logic [15:0]       max_sensor_gain,
  input  logic [6:0]        brightness,
  input  logic [9:0]        black_level,
  input  logic [3:0]        shift_factor,
  input  logic [63:0]       table_low_words,
  input  logic [63:0]       table_high_words,
  output logic [15:0]       analog_gain,
  output logic [23:0]       digital_gain,
  output logic [2:0]        table_step,
  output logic              sensor_changed,
  output logic              isp_changed,
  output logic              saturated
);

  logic [15:0]  total;
  logic [3:0]   scan;
  logic [2:0]   idx;
  logic         found;
  logic [2:0]   step_index;
  logic [15:0]  analog;
  logic [15:0]  last_analog;
  logic [23:0]  last_digital;
  logic [2:0]   mstep;
  logic [63:0]  prod;
  logic [63:0]  den;
  logic [63:0]  rem;
  logic [63:0]  num;
  logic [6:0]   dcnt;
  logic [QuotBits-1:0] quot;
  logic [3:0]   count;
  logic [15:0]  entry;
  logic [9:0]   room;
  logic [9:0]   blc_k;
  logic [8:0]   brt_num;
  logic [64:0]  trial;
  logic [23:0]  digital;
  logic         sat;

  function automatic logic [15:0] entry_at(input logic [2:0] i, input logic [63:0] lo,
                                           input logic [63:0] hi);
    logic [63:0] w;
    w = i[2] ? hi : lo;
    return w[{i[1:0], 4'd0} +: 16];
  endfunction

  assign count = (table_count > 4'(TableSteps)) ? 4'(TableSteps) : table_count;
  assign entry = entry_at(scan[2:0], table_low_words, table_high_words);
  assign blc_k = (black_level > 10'd1022) ? 10'd1022 : black_level;
  assign room = 10'd1023 - blc_k;
  assign brt_num = (brightness <= 7'd50) ? {2'b0, brightness}
                 : 9'({2'b0, brightness} * 9'd3 - 9'd100);
  assign status.search_done = found || (scan >= count);
  assign status.mult_done = (mstep == 3'd4);
  assign status.div_done = (dcnt == 7'd0);
  assign trial = {rem, num[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
      last_analog <= '0;
      last_digital <= '0;
      scan <= '0;
      found <= 1'b0;
      mstep <= '0;
      dcnt <= '0;
    end else begin
      if (cmd.load) begin
        total <= total_in;
        scan <= '0;
        idx <= '0;
        found <= 1'b0;
        mstep <= '0;
      end
      if (cmd.search_step) begin
        if (entry == total) begin
          idx <= scan[2:0];
          found <= 1'b1;
        end else if (entry > total) begin
          idx <= (scan == 4'd0) ? 3'd0 : 3'(scan - 4'd1);
          found <= 1'b1;
        end else begin
          idx <= scan[2:0];
          scan <= scan + 4'd1;
        end
      end
      if (cmd.mult_step) begin
        mstep <= mstep + 3'd1;
        case (mstep)
          3'd0: begin
            if (count == 4'd0) begin
              analog <= (total > max_sensor_gain) ? max_sensor_gain : total;
            end else begin
              step_index <= idx;
              analog <= entry_at(idx, table_low_words, table_high_words);
            end
            prod <= 64'(total) * 64'(brt_num);
          end
          3'd1: begin
            prod <= 64'(prod[24:0]) * 64'(18'd255750 + 18'(room));
            den <= 64'(analog) * 64'(14'd12500);
          end
          3'd2: begin
            prod <= (64'(prod[42:0]) * 64'({shift_factor, 1'b0})) << 12;
            den <= 64'(den[31:0]) * 64'(room);
          end
          3'd3: begin
            prod <= prod + (den >> 1);
          end
          default: begin
          end
        endcase
      end
      if (cmd.div_start) begin
        num <= prod;
        rem <= '0;
        quot <= '0;
        dcnt <= 7'(NumBits);
      end
      if (cmd.div_step) begin
        num <= num << 1;
        dcnt <= dcnt - 7'd1;
        if (!trial[64]) begin
          rem <= trial[63:0];
          quot <= {quot[QuotBits-2:0], 1'b1} | {QuotBits{quot[QuotBits-1]}};
        end else begin
          rem <= {rem[62:0], num[63]};
          quot <= {quot[QuotBits-2:0], 1'b0} | {QuotBits{quot[QuotBits-1]}};
        end
      end
      if (cmd.finish) begin
        analog_gain <= analog;
        digital_gain <= digital;
        table_step <= step_index;
        sensor_changed <= (analog != last_analog);
        isp_changed <= (digital != last_digital);
        saturated <= sat;
        last_analog <= analog;
        last_digital <= digital;
      end
    end
  end

  always_comb begin
    if (analog == 16'd0 || quot[24]) begin
      digital = DgainMax;
      sat = 1'b1;
    end else begin
      digital = quot[23:0];
      sat = 1'b0;
    end
  end

endmodule

>>> src/egs_control.sv
// ---------------------------------------------------------------------------
// Gain splitter controller
// Sequences search, product, division and output hand-off for one item.
// ---------------------------------------------------------------------------
module egs_control
  import egs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        enable,
  input  logic        out_take,
  input  egs_status_t status,
  output egs_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  egs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire && enable) state_next = ST_SEARCH;
      ST_SEARCH: if (status.search_done) state_next = ST_MULT;
      ST_MULT:   if (status.mult_done) state_next = ST_DIVIDE;
      ST_DIVIDE: if (status.div_done) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUTPUT;
      ST_OUTPUT: if (out_take) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = (state == ST_IDLE) && in_fire;
    cmd.search_step = (state == ST_SEARCH) && !status.search_done;
    cmd.mult_step = (state == ST_MULT) && !status.mult_done;
    cmd.div_start = (state == ST_MULT) && status.mult_done;
    cmd.div_step = (state == ST_DIVIDE) && !status.div_done;
    cmd.finish = (state == ST_FINISH);
    busy = (state != ST_IDLE);
    out_valid = (state == ST_OUTPUT);
  end

endmodule

>>> src/exposure_gain_splitter.sv
// ---------------------------------------------------------------------------
// Exposure gain splitter
// Splits a total exposure gain into analog sensor and digital ISP gains.
// ---------------------------------------------------------------------------
// One item on the slave stream carries a Q8.8 total gain per frame. The
// master stream returns analog gain, Q12.12 digital gain, table step and
// change and saturation flags. The user must write registers on the plain
// write port only while the block is idle; the block does not enforce it.
// One item is worked on at a time: table search, coefficient products and
// a restoring division of the 64-bit product run in that order, and the
// next item is taken once the result has been taken. While disabled an
// item is accepted and dropped. A stalled receiver holds the result and
// stalls the input. Reset restores register defaults and clears history.
// ---------------------------------------------------------------------------
module exposure_gain_splitter
  import egs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // total_gain
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // analog_gain, digital_gain, table_step,
                                 // sensor_changed, isp_changed, saturated, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic        enable;
  logic [3:0]  table_count;
  logic [15:0] max_sensor_gain;
  logic [6:0]  brightness;
  logic [9:0]  black_level;
  logic [3:0]  shift_factor;
  logic [63:0] table_low_words;
  logic [63:0] table_high_words;
  egs_cmd_t    cmd;
  egs_status_t status;
  logic        busy;
  logic        in_fire;
  logic [15:0] analog_gain;
  logic [23:0] digital_gain;
  logic [2:0]  table_step;
  logic        sensor_changed;
  logic        isp_changed;
  logic        saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
      table_count <= '0;
      max_sensor_gain <= 16'd4096;
      brightness <= 7'd50;
      black_level <= '0;
      shift_factor <= 4'd1;
      table_low_words <= '0;
      table_high_words <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegEnable:  enable <= cfg_data[0];
        RegCount:   table_count <= cfg_data[3:0];
        RegMaxGain: max_sensor_gain <= cfg_data[15:0];
        RegBright:  brightness <= cfg_data[6:0];
        RegBlack:   black_level <= cfg_data[9:0];
        RegShift:   shift_factor <= cfg_data[3:0];
        RegLow:     table_low_words <= cfg_data;
        RegHigh:    table_high_words <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready && enable;

  egs_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .enable    (enable),
    .out_take  (m_tready),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (m_tvalid)
  );

  egs_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .total_in         (s_tdata),
    .table_count      (table_count),
    .max_sensor_gain  (max_sensor_gain),
    .brightness       (brightness),
    .black_level      (black_level),
    .shift_factor     (shift_factor),
    .table_low_words  (table_low_words),
    .table_high_words (table_high_words),
    .analog_gain      (analog_gain),
    .digital_gain     (digital_gain),
    .table_step       (table_step),
    .sensor_changed   (sensor_changed),
    .isp_changed      (isp_changed),
    .saturated        (saturated)
  );

  assign m_tdata = {2'b00, saturated, isp_changed, sensor_changed, table_step,
                    digital_gain, analog_gain};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input accepted while a result waits");
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && saturated) |-> (digital_gain == DgainMax))
    else $error("saturated without maximum gain");
  a_out_after_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid) else $error("result not shown after finish");

endmodule
